// ===== sv/spd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// spd_pkg: shared constants, types and widths for the sensor packet deframer
// no dependencies; imported by the deframer top level and its checker

package spd_pkg;

  // packet layout
  localparam int unsigned PACKET_BYTES      = 8;
  localparam int unsigned MAX_FRAME_SAMPLES = 1024;

  // counter widths
  localparam int unsigned BYTE_CNT_W = 4;
  localparam int unsigned SUM_W      = 11;
  localparam int unsigned SAMPLE_W   = $clog2(MAX_FRAME_SAMPLES + 1);

  // field widths
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned VALUE_W    = 16;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned FSAMPLES_W = 11;

  // stream widths
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_FIELD_W = BYTE_W + 2 * VALUE_W + FSAMPLES_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int unsigned OUT_TUSER_W = KIND_W;

  // checksum modulus
  localparam logic [8:0] CSUM_MOD = 9'd255;

  // packet byte positions
  localparam logic [BYTE_CNT_W-1:0] POS_CMD   = 4'd1;
  localparam logic [BYTE_CNT_W-1:0] POS_XH    = 4'd2;
  localparam logic [BYTE_CNT_W-1:0] POS_XL    = 4'd3;
  localparam logic [BYTE_CNT_W-1:0] POS_YH    = 4'd4;
  localparam logic [BYTE_CNT_W-1:0] POS_YL    = 4'd5;
  localparam logic [BYTE_CNT_W-1:0] POS_FLAGS = 4'd6;
  localparam logic [BYTE_CNT_W-1:0] POS_CSUM  = BYTE_CNT_W'(PACKET_BYTES - 1);
  localparam logic [BYTE_CNT_W-1:0] POS_LAST  = BYTE_CNT_W'(PACKET_BYTES);

  // zero flag bits
  localparam int unsigned FLAG_XL = 0;
  localparam int unsigned FLAG_XH = 1;
  localparam int unsigned FLAG_YL = 2;
  localparam int unsigned FLAG_YH = 3;

  // command codes
  localparam logic [BYTE_W-1:0] CMD_SAMPLE      = 8'd1;
  localparam logic [BYTE_W-1:0] CMD_FRAME_START = 8'd2;
  localparam logic [BYTE_W-1:0] CMD_FRAME_END   = 8'd3;
  localparam logic [BYTE_W-1:0] CMD_POWER       = 8'd20;

  // event classification
  typedef enum logic [KIND_W-1:0] {
    KIND_SAMPLE      = 3'd0,
    KIND_FRAME_START = 3'd1,
    KIND_FRAME_END   = 3'd2,
    KIND_POWER       = 3'd3,
    KIND_OTHER       = 3'd4
  } event_kind_e;

endpackage

`default_nettype wire

// ===== sv/sensor_packet_deframer_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// sensor_packet_deframer_top: byte stream in, decoded eight-byte packets out
// depends on spd_pkg

// The block takes one link byte per cycle on the slave stream and emits one
// decoded packet on the master stream for every eight-byte packet whose
// checksum matches; bad packets produce nothing. A zero byte always restarts
// a packet. Each byte is handled in the cycle it is accepted: the running sum,
// byte position and held fields update at once, and a packet that closes with
// a good checksum is loaded straight into the output register, so the result
// shows on the master side the cycle after its checksum byte is accepted.
// One byte is taken every cycle; input ready drops only when the checksum byte
// of a packet is due while the previous packet still sits in the output
// register and the downstream side is not ready.

module sensor_packet_deframer_top (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // request in
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [spd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] rx_byte
  // request out
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [7:0] command_code, [23:8] x_value, [39:24] y_value,
  // [50:40] frame_samples, [55:51] zero
  output logic [spd_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  output logic [spd_pkg::OUT_TUSER_W-1:0]      m_axis_tuser    // [2:0] event_kind
);

  import spd_pkg::*;

  // control state
  logic [BYTE_CNT_W-1:0] byte_count_q, byte_count_d;
  logic [SUM_W-1:0]      running_sum_q, running_sum_d;
  logic [SAMPLE_W-1:0]   sample_counter_q, sample_counter_d;
  logic                  out_valid_q, out_valid_d;

  // held packet bytes
  logic [BYTE_W-1:0] held_cmd_q;
  logic [BYTE_W-1:0] held_xh_q, held_xl_q, held_yh_q, held_yl_q;
  logic [BYTE_W-1:0] held_flags_q;

  // output payload
  logic [BYTE_W-1:0]     out_cmd_q;
  logic [VALUE_W-1:0]    out_x_q, out_x_d;
  logic [VALUE_W-1:0]    out_y_q, out_y_d;
  event_kind_e           out_kind_q, kind_d;
  logic [FSAMPLES_W-1:0] out_samples_q, out_samples_d;

  logic [BYTE_W-1:0]     rx_byte;
  logic                  in_accept;
  logic                  is_zero;
  logic [BYTE_CNT_W-1:0] pos;
  logic [SUM_W-1:0]      sum_eff;
  logic [8:0]            fold_sum;
  logic [BYTE_W-1:0]     csum_mod;
  logic                  pkt_ok;
  logic [SAMPLE_W+FSAMPLES_W-1:0] samples_ext;

  assign rx_byte   = s_axis_tdata[BYTE_W-1:0];
  // only the checksum byte has to wait for a free output register
  assign s_axis_tready = !out_valid_q || m_axis_tready || (byte_count_q != POS_CSUM);
  assign in_accept = s_axis_tvalid && s_axis_tready;

  // a zero byte restarts the packet at position zero
  assign is_zero = (rx_byte == '0);
  assign pos     = is_zero ? '0 : byte_count_q;
  assign sum_eff = is_zero ? '0 : running_sum_q;

  // sum mod 255: fold the high bits onto the low byte, then one correction
  assign fold_sum = {6'd0, running_sum_q[SUM_W-1:BYTE_W]} + {1'b0, running_sum_q[BYTE_W-1:0]};
  always_comb begin
    if (fold_sum >= CSUM_MOD) begin
      csum_mod = BYTE_W'(fold_sum - CSUM_MOD);
    end else begin
      csum_mod = fold_sum[BYTE_W-1:0];
    end
  end

  assign pkt_ok = in_accept && (pos == POS_CSUM) && (csum_mod == rx_byte);

  // position and running sum
  always_comb begin
    byte_count_d  = byte_count_q;
    running_sum_d = running_sum_q;
    if (in_accept) begin
      if (pos <= POS_LAST) begin
        byte_count_d = pos + 1'b1;
      end else begin
        byte_count_d = pos;
      end
      if (pos < POS_CSUM) begin
        running_sum_d = sum_eff + {3'd0, rx_byte};
      end else begin
        running_sum_d = sum_eff;
      end
    end
  end

  // zero flags clear the marked bytes
  always_comb begin
    out_x_d = {held_flags_q[FLAG_XH] ? 8'd0 : held_xh_q,
               held_flags_q[FLAG_XL] ? 8'd0 : held_xl_q};
    out_y_d = {held_flags_q[FLAG_YH] ? 8'd0 : held_yh_q,
               held_flags_q[FLAG_YL] ? 8'd0 : held_yl_q};
  end

  // command classification and per-frame sample count
  always_comb begin
    sample_counter_d = sample_counter_q;
    case (held_cmd_q)
      CMD_SAMPLE: begin
        kind_d = KIND_SAMPLE;
        if (sample_counter_q < SAMPLE_W'(MAX_FRAME_SAMPLES)) begin
          sample_counter_d = sample_counter_q + 1'b1;
        end
      end
      CMD_FRAME_START: begin
        kind_d           = KIND_FRAME_START;
        sample_counter_d = '0;
      end
      CMD_FRAME_END: kind_d = KIND_FRAME_END;
      CMD_POWER:     kind_d = KIND_POWER;
      default:       kind_d = KIND_OTHER;
    endcase
  end

  assign samples_ext   = {{FSAMPLES_W{1'b0}}, sample_counter_d};
  assign out_samples_d = samples_ext[FSAMPLES_W-1:0];

  // output handshake
  always_comb begin
    out_valid_d = out_valid_q;
    if (pkt_ok) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q     <= '0;
      running_sum_q    <= '0;
      sample_counter_q <= '0;
      out_valid_q      <= 1'b0;
    end else begin
      byte_count_q  <= byte_count_d;
      running_sum_q <= running_sum_d;
      out_valid_q   <= out_valid_d;
      if (pkt_ok) begin
        sample_counter_q <= sample_counter_d;
      end
    end
  end

  // held packet bytes, written as they arrive
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      case (pos)
        POS_CMD:   held_cmd_q   <= rx_byte;
        POS_XH:    held_xh_q    <= rx_byte;
        POS_XL:    held_xl_q    <= rx_byte;
        POS_YH:    held_yh_q    <= rx_byte;
        POS_YL:    held_yl_q    <= rx_byte;
        POS_FLAGS: held_flags_q <= rx_byte;
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (pkt_ok) begin
      out_cmd_q     <= held_cmd_q;
      out_x_q       <= out_x_d;
      out_y_q       <= out_y_d;
      out_kind_q    <= kind_d;
      out_samples_q <= out_samples_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'({out_samples_q, out_y_q, out_x_q, out_cmd_q});
  assign m_axis_tuser  = out_kind_q;

endmodule

`default_nettype wire

// ===== sv/spd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// spd_checker: port-level assertions for the sensor packet deframer
// depends on spd_pkg; bound to sensor_packet_deframer_top

module spd_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            s_axis_tvalid,
  input wire logic                            s_axis_tready,
  input wire logic [spd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input wire logic                            m_axis_tvalid,
  input wire logic                            m_axis_tready,
  input wire logic [spd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input wire logic [spd_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);

  import spd_pkg::*;

  logic [FSAMPLES_W-1:0] samples;
  assign samples = m_axis_tdata[OUT_FIELD_W-1:BYTE_W+2*VALUE_W];

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // a frame start always reports an empty frame
  a_start_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_FRAME_START) |-> samples == '0)
    else $error("frame start with nonzero sample count");

  // a sample always reports at least one sample
  a_sample_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_SAMPLE) |-> samples != '0)
    else $error("sample with zero count");

  // a result needs a nonzero checksum byte accepted the cycle before
  a_result_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && (s_axis_tdata != '0)))
    else $error("result without a closing byte");

endmodule

bind sensor_packet_deframer_top spd_checker u_spd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== tb/sensor_packet_deframer_top_test.sv =====
`timescale 1ns / 1ps
// sensor_packet_deframer_top_test: self-checking bench for the packet deframer
// drives link bytes in, predicts each decoded packet and checks the output stream
// depends on spd_pkg and sensor_packet_deframer_top

module sensor_packet_deframer_top_test;
  import spd_pkg::*;

  // one decoded packet as seen on the master stream
  typedef struct {
    logic [BYTE_W-1:0]     cmd;
    logic [VALUE_W-1:0]    x;
    logic [VALUE_W-1:0]    y;
    event_kind_e           kind;
    logic [FSAMPLES_W-1:0] samples;
  } decoded_pkt_t;

  // deframer predictor plus the queue of packets it still owes
  class deframe_scoreboard;
    logic [BYTE_CNT_W-1:0] pos_count;
    logic [SUM_W-1:0]      byte_sum;
    logic [BYTE_W-1:0]     cmd_hold;
    logic [BYTE_W-1:0]     field_hold [4];
    logic [BYTE_W-1:0]     flag_hold;
    logic [SAMPLE_W-1:0]   sample_count;
    decoded_pkt_t          decoded_q [$];
    int unsigned           bytes_in;
    int unsigned           pkts_checked;
    int unsigned           kind_hits [5];
    int unsigned           errors;

    function new();
      pos_count    = '0;
      byte_sum     = '0;
      cmd_hold     = '0;
      flag_hold    = '0;
      sample_count = '0;
      foreach (field_hold[i]) field_hold[i] = '0;
      foreach (kind_hits[i]) kind_hits[i] = 0;
      bytes_in     = 0;
      pkts_checked = 0;
      errors       = 0;
    endfunction

    // count a failure, print only the first few
    function void flag_error(string msg);
      errors++;
      if (errors <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    // accepted link byte: advance the deframer and queue any packet it completes
    function void take_link_byte(logic [BYTE_W-1:0] b);
      logic [BYTE_CNT_W-1:0] pos;
      decoded_pkt_t          p;
      bytes_in++;
      // a zero byte always opens a new packet
      if (b == '0) begin
        pos_count = '0;
        byte_sum  = '0;
      end
      if (pos_count > POS_LAST) return;
      pos       = pos_count;
      pos_count = pos + 1'b1;
      // header and body bytes are summed and held
      if (pos < POS_CSUM) begin
        byte_sum = byte_sum + b;
        case (pos)
          POS_CMD:   cmd_hold = b;
          POS_XH:    field_hold[0] = b;
          POS_XL:    field_hold[1] = b;
          POS_YH:    field_hold[2] = b;
          POS_YL:    field_hold[3] = b;
          POS_FLAGS: flag_hold = b;
          default: ;
        endcase
        return;
      end
      // only the checksum position can complete a packet
      if (pos != POS_CSUM) return;
      if ((byte_sum % CSUM_MOD) != b) return;
      p.cmd = cmd_hold;
      p.x = {(flag_hold[FLAG_XH] ? 8'h00 : field_hold[0]),
             (flag_hold[FLAG_XL] ? 8'h00 : field_hold[1])};
      p.y = {(flag_hold[FLAG_YH] ? 8'h00 : field_hold[2]),
             (flag_hold[FLAG_YL] ? 8'h00 : field_hold[3])};
      // classify and keep the per-frame sample count
      case (cmd_hold)
        CMD_SAMPLE: begin
          p.kind = KIND_SAMPLE;
          if (sample_count < MAX_FRAME_SAMPLES) sample_count = sample_count + 1'b1;
        end
        CMD_FRAME_START: begin
          p.kind       = KIND_FRAME_START;
          sample_count = '0;
        end
        CMD_FRAME_END: p.kind = KIND_FRAME_END;
        CMD_POWER:     p.kind = KIND_POWER;
        default:       p.kind = KIND_OTHER;
      endcase
      p.samples = FSAMPLES_W'(sample_count);
      kind_hits[p.kind]++;
      decoded_q = {decoded_q, p};
    endfunction

    // accepted output packet: compare with the oldest prediction
    function void check_decoded(logic [OUT_TDATA_W-1:0] data, logic [OUT_TUSER_W-1:0] user);
      decoded_pkt_t want;
      if (decoded_q.size() == 0) begin
        flag_error($sformatf("packet with none expected: tdata %h tuser %h", data, user));
        return;
      end
      want = decoded_q.pop_front();
      pkts_checked++;
      if (data[BYTE_W-1:0] !== want.cmd
          || data[BYTE_W +: VALUE_W] !== want.x
          || data[BYTE_W+VALUE_W +: VALUE_W] !== want.y
          || data[BYTE_W+2*VALUE_W +: FSAMPLES_W] !== want.samples
          || data[OUT_TDATA_W-1:OUT_FIELD_W] !== '0
          || user !== want.kind)
        flag_error($sformatf({"exp cmd %h x %h y %h kind %0d samples %0d, ",
                              "got cmd %h x %h y %h kind %0d samples %0d pad %h"},
                             want.cmd, want.x, want.y, want.kind, want.samples,
                             data[BYTE_W-1:0], data[BYTE_W +: VALUE_W],
                             data[BYTE_W+VALUE_W +: VALUE_W], user,
                             data[BYTE_W+2*VALUE_W +: FSAMPLES_W],
                             data[OUT_TDATA_W-1:OUT_FIELD_W]));
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;

  deframe_scoreboard sb;
  bit                stall_en;

  sensor_packet_deframer_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 12 ns clock
  always #6 clk_i = ~clk_i;

  // random nonzero link byte
  function automatic logic [BYTE_W-1:0] rand_nz();
    return BYTE_W'($urandom_range(255, 1));
  endfunction

  // offer one byte, return at the edge where the request is taken
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    @(negedge clk_i);
    while (stall_en && $urandom_range(99, 0) < 31) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.take_link_byte(b);
  endtask

  // full packet from a zero sync byte, checksum optionally broken
  task automatic send_packet(input logic [BYTE_W-1:0] cmd, input logic [BYTE_W-1:0] xh,
                             input logic [BYTE_W-1:0] xl, input logic [BYTE_W-1:0] yh,
                             input logic [BYTE_W-1:0] yl, input logic [BYTE_W-1:0] flags,
                             input bit corrupt);
    logic [SUM_W-1:0]  total;
    logic [BYTE_W-1:0] csum;
    total = SUM_W'(cmd) + xh + xl + yh + yl + flags;
    csum  = BYTE_W'(total % CSUM_MOD);
    if (corrupt) csum = csum + BYTE_W'($urandom_range(254, 1));
    send_byte('0);
    send_byte(cmd);
    send_byte(xh);
    send_byte(xl);
    send_byte(yh);
    send_byte(yl);
    send_byte(flags);
    send_byte(csum);
  endtask

  // packet with a random command mix and random body
  task automatic send_random_packet(input bit corrupt);
    logic [BYTE_W-1:0] cmd;
    int unsigned       pick;
    pick = $urandom_range(9, 0);
    if (pick < 4)       cmd = CMD_SAMPLE;
    else if (pick == 4) cmd = CMD_FRAME_START;
    else if (pick == 5) cmd = CMD_FRAME_END;
    else if (pick == 6) cmd = CMD_POWER;
    else                cmd = rand_nz();
    send_packet(cmd, rand_nz(), rand_nz(), rand_nz(), rand_nz(), rand_nz(), corrupt);
  endtask

  // drop valid and hold off until every predicted packet is out
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.decoded_q.size() != 0) @(negedge clk_i);
  endtask

  // downstream ready with random stalls
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      m_axis_tready <= !(stall_en && $urandom_range(99, 0) < 31);
    end
  end

  // output monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_decoded(m_axis_tdata, m_axis_tuser);
  end

  // stimulus and end of run
  initial begin
    int unsigned stop_at;
    int unsigned pkt_idx;
    int unsigned pick;
    sb            = new();
    stall_en      = 1'b1;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // stream start without a sync byte: all-ones body, high flag bits only
    send_byte(8'hFF);
    send_byte(CMD_FRAME_START);
    repeat (4) send_byte(8'hFF);
    send_byte(8'hF0);
    send_byte(8'd242);
    // bytes past the eighth are ignored
    send_byte(8'h80);
    send_byte(8'h7F);
    // zero in the checksum slot restarts the packet
    send_byte('0);
    send_byte(CMD_SAMPLE);
    send_byte(8'h12);
    send_byte(8'h34);
    send_byte(8'h56);
    send_byte(8'h78);
    send_byte(8'h0F);
    // its zero is the sync byte of a power packet with every field cleared
    send_packet(CMD_POWER, 8'h01, 8'h80, 8'hFE, 8'h7F, 8'h0F, 1'b0);
    // bad checksum is dropped
    send_packet(CMD_FRAME_END, 8'hA5, 8'h5A, 8'hC3, 8'h3C, 8'h05, 1'b1);

    // random mix up to about 1500 link bytes in total
    stop_at = 1500;
    pkt_idx = 0;
    while (sb.bytes_in < stop_at) begin
      stall_en = !(pkt_idx >= 60 && pkt_idx < 95);
      if (pkt_idx == 120) drain_results();
      pick = $urandom_range(99, 0);
      if (pick < 80) begin
        send_random_packet($urandom_range(9, 0) == 0);
      end else if (pick < 90) begin
        send_random_packet(1'b0);
        repeat ($urandom_range(5, 1)) send_byte(rand_nz());
      end else begin
        repeat ($urandom_range(10, 1)) send_byte(BYTE_W'($urandom_range(255, 0)));
      end
      pkt_idx++;
    end

    // let the pipeline settle, then anything left over is a failure
    stall_en = 1'b1;
    drain_results();
    repeat (20) @(posedge clk_i);
    if (sb.decoded_q.size() != 0)
      sb.flag_error($sformatf("%0d packets never came out", sb.decoded_q.size()));
    $display("covered %0d link bytes and %0d decoded packets, %0d mismatches",
             sb.bytes_in, sb.pkts_checked, sb.errors);
    $display("kinds sample %0d start %0d end %0d power %0d other %0d, final sample count %0d",
             sb.kind_hits[KIND_SAMPLE], sb.kind_hits[KIND_FRAME_START],
             sb.kind_hits[KIND_FRAME_END], sb.kind_hits[KIND_POWER],
             sb.kind_hits[KIND_OTHER], sb.sample_count);
    if (sb.errors == 0) begin
      $display("sensor_packet_deframer_top test passed");
    end else begin
      $display("sensor_packet_deframer_top test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20000000;
    $display("sensor_packet_deframer_top test failed");
    $finish;
  end

endmodule
